/* hdl/kmer_histogram_counter_unit_defines.svh */
// assertion macros shared by the kmer histogram counter rtl
// no dependencies; the including module provides clk and arst_n
`ifndef KMER_HISTOGRAM_COUNTER_UNIT_DEFINES_SVH
`define KMER_HISTOGRAM_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define KHC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KHC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KHC_ASSERT(label, prop, msg)
`define KHC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hdl/khc_pkg.sv */
// types, constants and helpers for the kmer histogram counter
// used by every module of the block; no dependencies
package khc_pkg;

	localparam int MAX_K       = 8;
	localparam int ID_W        = 2 * MAX_K;
	localparam int COUNT_W     = 32;
	localparam int TOTAL_W     = 24;
	localparam int STORE_DEPTH = 1 << ID_W;
	localparam int NUM_TOTALS  = 5;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int K_W         = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;

	localparam logic [K_W-1:0] K_RESET = 4'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_CHECK = 1'd1;

	// opcodes
	localparam logic [1:0] OP_BASE       = 2'd0;
	localparam logic [1:0] OP_READ       = 2'd1;
	localparam logic [1:0] OP_READ_CLEAR = 2'd2;

	// characters
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_C  = 8'h43;
	localparam logic [7:0] CH_G  = 8'h47;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_U  = 8'h55;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_X  = 8'h58;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// per-sequence total slots
	localparam int T_MASKED = 0;
	localparam int T_UNSYL  = 1;
	localparam int T_SYL    = 2;
	localparam int T_SPACED = 3;
	localparam int T_R2     = 4;

	typedef enum logic [2:0] {
		EV_NOT_FULL = 3'd0,
		EV_COUNTED  = 3'd1,
		EV_MASKED   = 3'd2,
		EV_REPEAT   = 3'd3,
		EV_BIN_READ = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		MOP_NONE  = 2'd0,
		MOP_INCR  = 2'd1,
		MOP_READ  = 2'd2,
		MOP_CLEAR = 2'd3
	} mem_op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  base_char;
		logic        last;
		logic [15:0] bin_index;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]    kmer_id;
		event_t             event_res;
		logic [COUNT_W-1:0] bin_count;
		logic               seq_end;
		logic               seq_short;
		logic [TOTAL_W-1:0] seq_masked;
		logic [TOTAL_W-1:0] seq_unsyl;
		logic [TOTAL_W-1:0] seq_syl;
		logic [TOTAL_W-1:0] seq_spaced;
		logic [TOTAL_W-1:0] seq_r2;
		logic [TOTAL_W-1:0] seq_bases;
	} result_t;

	// classified item waiting for the count memory
	typedef struct packed {
		mem_op_t            mop;
		logic [ID_W-1:0]    kmer_id;
		event_t             event_res;
		logic               seq_end;
		logic               seq_short;
		logic [TOTAL_W-1:0] seq_masked;
		logic [TOTAL_W-1:0] seq_unsyl;
		logic [TOTAL_W-1:0] seq_syl;
		logic [TOTAL_W-1:0] seq_spaced;
		logic [TOTAL_W-1:0] seq_r2;
		logic [TOTAL_W-1:0] seq_bases;
	} qent_t;

	function automatic logic [TOTAL_W-1:0] sat_inc_total(input logic [TOTAL_W-1:0] v);
		sat_inc_total = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc_count(input logic [COUNT_W-1:0] v);
		sat_inc_count = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

/* hdl/khc_front.sv */
// front end: accepts items, keeps the rolling word and per-sequence state
// and classifies each item into a memory operation; uses khc_pkg
module khc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [khc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [khc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          item_valid,
	input  logic                          stall,
	input  khc_pkg::item_t                item,
	output logic                          push,
	output khc_pkg::qent_t                entry
);
	import khc_pkg::*;

	logic [K_W-1:0]     kmer_length_q;
	logic               repeat_check_q;
	logic [ID_W-1:0]    win_q;
	logic [MAX_K-1:0]   mask_q;
	logic [2:0]         phase_q;
	logic [ID_W-1:0]    recent_q [2];
	logic [1:0]         recent_vld_q;
	logic [TOTAL_W-1:0] pos_q;
	logic [TOTAL_W-1:0] tot_q [NUM_TOTALS];

	logic [ID_W-1:0]    win_n;
	logic [MAX_K-1:0]   mask_n;
	logic [2:0]         phase_n;
	logic [ID_W-1:0]    recent_n [2];
	logic [1:0]         recent_vld_n;
	logic [TOTAL_W-1:0] pos_n;
	logic [TOTAL_W-1:0] tot_n [NUM_TOTALS];

	logic               is_base;

	assign push    = item_valid && !stall;
	assign is_base = (item.opcode == OP_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q  <= K_RESET;
			repeat_check_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KMER_LENGTH:  kmer_length_q  <= cfg_data[K_W-1:0];
				CFG_REPEAT_CHECK: repeat_check_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [K_W-1:0]   k_eff;
		logic [ID_W-1:0]  id_mask;
		logic [MAX_K-1:0] win_mask;
		logic [1:0]       code;
		logic             masked;
		logic             full;
		logic             first;
		logic             hit;

		k_eff = kmer_length_q;
		if (kmer_length_q == '0)
			k_eff = K_W'(1);
		else if (kmer_length_q > K_W'(MAX_K))
			k_eff = K_W'(MAX_K);
		for (int j = 0; j < MAX_K; j++) begin
			id_mask[2*j +: 2] = (K_W'(j) < k_eff) ? 2'b11 : 2'b00;
			win_mask[j]       = (K_W'(j) < k_eff);
		end

		masked = 1'b0;
		code   = 2'd0;
		case (item.base_char)
			CH_A:                     code = 2'd0;
			CH_C:                     code = 2'd1;
			CH_G:                     code = 2'd2;
			CH_T, CH_U:               code = 2'd3;
			CH_N, CH_X, CH_LF, CH_CR: masked = 1'b1;
			default:                  masked = 1'b1;
		endcase

		mask_n       = {mask_q[MAX_K-2:0], masked};
		win_n        = {win_q[ID_W-3:0], code} & id_mask;
		recent_n     = recent_q;
		recent_vld_n = recent_vld_q;
		tot_n        = tot_q;
		pos_n        = sat_inc_total(pos_q);

		if (masked) begin
			tot_n[T_MASKED] = sat_inc_total(tot_q[T_MASKED]);
			phase_n         = 3'd0;
		end else if (({1'b0, phase_q} + 4'd1) >= k_eff) begin
			tot_n[T_SPACED] = sat_inc_total(tot_q[T_SPACED]);
			phase_n         = 3'd0;
		end else begin
			phase_n = phase_q + 3'd1;
		end

		full  = pos_q >= TOTAL_W'(k_eff - K_W'(1));
		first = pos_q == TOTAL_W'(k_eff - K_W'(1));
		hit   = repeat_check_q &&
			((recent_vld_q[0] && recent_q[0] == win_n) ||
			 (recent_vld_q[1] && recent_q[1] == win_n));

		entry           = '0;
		entry.kmer_id   = win_n;
		entry.event_res = EV_NOT_FULL;
		entry.mop       = MOP_NONE;

		if (!is_base) begin
			entry.kmer_id   = item.bin_index;
			entry.event_res = EV_BIN_READ;
			entry.mop       = (item.opcode == OP_READ_CLEAR) ? MOP_CLEAR : MOP_READ;
		end else begin
			if (full) begin
				if (|(mask_n & win_mask)) begin
					tot_n[T_UNSYL]  = sat_inc_total(tot_q[T_UNSYL]);
					entry.event_res = EV_MASKED;
				end else if (first) begin
					recent_n[0]     = win_n;
					recent_vld_n[0] = 1'b1;
					tot_n[T_SYL]    = sat_inc_total(tot_q[T_SYL]);
					entry.event_res = EV_COUNTED;
					entry.mop       = MOP_INCR;
				end else if (hit) begin
					tot_n[T_R2]     = sat_inc_total(tot_q[T_R2]);
					entry.event_res = EV_REPEAT;
					entry.mop       = MOP_READ;
				end else begin
					recent_n[pos_q[0]]     = win_n;
					recent_vld_n[pos_q[0]] = 1'b1;
					tot_n[T_SYL]           = sat_inc_total(tot_q[T_SYL]);
					entry.event_res        = EV_COUNTED;
					entry.mop              = MOP_INCR;
				end
			end
			if (item.last) begin
				entry.seq_end = 1'b1;
				if (pos_n < TOTAL_W'(k_eff)) begin
					entry.seq_short = 1'b1;
				end else begin
					entry.seq_masked = tot_n[T_MASKED];
					entry.seq_unsyl  = tot_n[T_UNSYL];
					entry.seq_syl    = tot_n[T_SYL];
					entry.seq_spaced = tot_n[T_SPACED];
					entry.seq_r2     = tot_n[T_R2];
					entry.seq_bases  = pos_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= '0;
			mask_q       <= '0;
			phase_q      <= '0;
			recent_q[0]  <= '0;
			recent_q[1]  <= '0;
			recent_vld_q <= '0;
			pos_q        <= '0;
			for (int t = 0; t < NUM_TOTALS; t++)
				tot_q[t] <= '0;
		end else if (push && is_base) begin
			if (item.last) begin
				// sequence done: back to the reset state
				win_q        <= '0;
				mask_q       <= '0;
				phase_q      <= '0;
				recent_q[0]  <= '0;
				recent_q[1]  <= '0;
				recent_vld_q <= '0;
				pos_q        <= '0;
				for (int t = 0; t < NUM_TOTALS; t++)
					tot_q[t] <= '0;
			end else begin
				win_q        <= win_n;
				mask_q       <= mask_n;
				phase_q      <= phase_n;
				recent_q     <= recent_n;
				recent_vld_q <= recent_vld_n;
				pos_q        <= pos_n;
				tot_q        <= tot_n;
			end
		end
	end

endmodule

/* hdl/khc_fifo.sv */
// short queue of classified items between the front and back ends
// uses khc_pkg for the entry type and depth
`include "kmer_histogram_counter_unit_defines.svh"
module khc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  khc_pkg::qent_t wr_entry,
	input  logic           pop,
	output khc_pkg::qent_t rd_entry,
	output logic           full,
	output logic           empty
);
	import khc_pkg::*;

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`KHC_ASSERT(a_no_push_when_full, full |-> !push, "push into a full queue")
	`KHC_ASSERT(a_no_pop_when_empty, empty |-> !pop, "pop from an empty queue")

endmodule

/* hdl/khc_back.sv */
// back end: clears the count memory after reset, then reads the count for
// each item and writes back increments and clears, with write forwarding; uses khc_pkg
`include "kmer_histogram_counter_unit_defines.svh"
module khc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  khc_pkg::qent_t  q_entry,
	input  logic            q_empty,
	output logic            pop,
	output logic            busy,
	output logic            result_valid,
	input  logic            result_stall,
	output khc_pkg::result_t result
);
	import khc_pkg::*;

	logic [COUNT_W-1:0] count_mem [STORE_DEPTH];

	logic               clr_active_q;
	logic [ID_W-1:0]    clr_addr_q;
	qent_t              s1_q;
	logic               s1_valid_q;
	logic [COUNT_W-1:0] rdata_s1;
	logic               fwd_valid_q;
	logic [ID_W-1:0]    fwd_addr_q;
	logic [COUNT_W-1:0] fwd_data_q;
	result_t            out_q;
	logic               out_valid_q;

	logic               s1_adv;
	logic               wr_en;
	logic [COUNT_W-1:0] cur_count;
	logic [COUNT_W-1:0] new_count;
	logic [COUNT_W-1:0] shown_count;

	assign busy         = clr_active_q;
	assign s1_adv       = s1_valid_q && (!out_valid_q || !result_stall);
	assign pop          = !q_empty && !clr_active_q && (!s1_valid_q || s1_adv);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// the write of the item just ahead can land on the edge this item read
	assign cur_count = (fwd_valid_q && fwd_addr_q == s1_q.kmer_id) ? fwd_data_q : rdata_s1;

	always_comb begin
		new_count   = cur_count;
		shown_count = '0;
		wr_en       = 1'b0;
		case (s1_q.mop)
			MOP_INCR: begin
				new_count   = sat_inc_count(cur_count);
				shown_count = new_count;
				wr_en       = s1_adv;
			end
			MOP_CLEAR: begin
				new_count   = '0;
				shown_count = cur_count;
				wr_en       = s1_adv;
			end
			MOP_READ: shown_count = cur_count;
			default:  shown_count = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clr_active_q)
			count_mem[clr_addr_q] <= '0;
		else if (wr_en)
			count_mem[s1_q.kmer_id] <= new_count;
		if (pop)
			rdata_s1 <= count_mem[q_entry.kmer_id];
		if (pop)
			s1_q <= q_entry;
		if (s1_adv) begin
			out_q.kmer_id    <= s1_q.kmer_id;
			out_q.event_res  <= s1_q.event_res;
			out_q.bin_count  <= shown_count;
			out_q.seq_end    <= s1_q.seq_end;
			out_q.seq_short  <= s1_q.seq_short;
			out_q.seq_masked <= s1_q.seq_masked;
			out_q.seq_unsyl  <= s1_q.seq_unsyl;
			out_q.seq_syl    <= s1_q.seq_syl;
			out_q.seq_spaced <= s1_q.seq_spaced;
			out_q.seq_r2     <= s1_q.seq_r2;
			out_q.seq_bases  <= s1_q.seq_bases;
		end
		if (wr_en) begin
			fwd_addr_q <= s1_q.kmer_id;
			fwd_data_q <= new_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			fwd_valid_q  <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == {ID_W{1'b1}})
					clr_active_q <= 1'b0;
			end
			if (pop)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (wr_en)
				fwd_valid_q <= 1'b1;
		end
	end

	`KHC_ASSERT(a_idle_while_clearing, clr_active_q |-> (!s1_valid_q && !out_valid_q), "item during clear")
	`KHC_ASSERT(a_s1_holds, (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)), "s1 lost item")
	`KHC_ASSERT(a_fwd_tracks_write, wr_en |=> (fwd_valid_q && fwd_addr_q == $past(s1_q.kmer_id)), "fwd stale")

endmodule

/* hdl/kmer_histogram_counter_unit.sv */
// top level of the kmer histogram counter: front end, queue, back end
// depends on khc_pkg, khc_front, khc_fifo and khc_back
//
//  channel   handshake                  payload
//  item      item_valid / item_stall    item   (khc_pkg::item_t)
//  result    result_valid / result_stall result (khc_pkg::result_t)
//  config    cfg_write                  cfg_index, cfg_data
//
// one item per cycle sustained while result_stall stays low; an item passes through the queue,
// the s1 register and the output register before its result appears; the rate is set by
// the count memory: one read and one write per cycle, with the write of the previous item forwarded to the next read
// after reset the 65536 entries of the count memory are cleared, with item_stall high;
// configuration writes are taken during that time
// the queue lets items enter while a result waits on result_stall
module kmer_histogram_counter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [khc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [khc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  khc_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output khc_pkg::result_t              result
);
	import khc_pkg::*;

	qent_t front_entry;
	qent_t head_entry;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	logic  back_busy;

	assign item_stall = q_full || back_busy;

	khc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.stall      (item_stall),
		.item       (item),
		.push       (push),
		.entry      (front_entry)
	);

	khc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (front_entry),
		.pop      (pop),
		.rd_entry (head_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	khc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_entry      (head_entry),
		.q_empty      (q_empty),
		.pop          (pop),
		.busy         (back_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
